FILE: hdl/sbct_pkg.sv
package sbct_pkg;

    localparam int POINT_DEPTH = 64;
    localparam int PT_IDX_W    = $clog2(POINT_DEPTH);
    localparam int CNT_W       = $clog2(POINT_DEPTH + 1);
    localparam int IDX_W       = 10;
    localparam int DIV_W       = 48;
    localparam int EXP_STEPS   = 24;

    // Operation codes of an input item.
    localparam logic [3:0] OP_QUERY = 4'd0;
    localparam logic [3:0] OP_ADD   = 4'd1;
    localparam logic [3:0] OP_SET_C = 4'd2;
    localparam logic [3:0] OP_SET_K = 4'd3;
    localparam logic [3:0] OP_CURVE = 4'd4;
    localparam logic [3:0] OP_NTH   = 4'd5;
    localparam logic [3:0] OP_CLEAR = 4'd6;
    localparam logic [3:0] OP_ERASE = 4'd7;
    localparam logic [3:0] OP_DUMP  = 4'd8;
    localparam logic [3:0] OP_RAMP  = 4'd9;

    // Result kinds.
    localparam logic [1:0] KIND_Y    = 2'd0;
    localparam logic [1:0] KIND_RAMP = 2'd1;
    localparam logic [1:0] KIND_DUMP = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_Y_BOUND_A = 2'd0;
    localparam logic [1:0] REG_Y_BOUND_B = 2'd1;
    localparam logic [1:0] REG_CAPACITY  = 2'd2;

    // Commands broadcast to the cell chain.
    localparam logic [2:0] CELL_NOP    = 3'd0;
    localparam logic [2:0] CELL_INSERT = 3'd1;
    localparam logic [2:0] CELL_WRITE  = 3'd2;
    localparam logic [2:0] CELL_ERASE  = 3'd3;
    localparam logic [2:0] CELL_CURVE  = 3'd4;
    localparam logic [2:0] CELL_LOAD   = 3'd5;
    localparam logic [2:0] CELL_SHIFT  = 3'd6;

    typedef struct packed {
        logic [3:0]        operation;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [15:0] curve_in;
        logic [IDX_W-1:0]  index_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [IDX_W-1:0]   index_out;
        logic [30:0]        x_out;
        logic signed [31:0] y_out;
        logic signed [15:0] curve_out;
        logic [30:0]        time_out;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [30:0]        x;
        logic signed [31:0] y;
        logic signed [15:0] curve;
    } point_t;

    typedef struct packed {
        logic [2:0]          op;
        logic [PT_IDX_W-1:0] pos;
        point_t              pt;
    } cell_cmd_t;

    typedef struct packed {
        logic [30:0]        x;
        logic [30:0]        xl;
        logic signed [31:0] yl;
        logic [30:0]        xr;
        logic signed [31:0] yr;
        logic signed [15:0] cr;
    } seg_t;

    typedef logic [31:0] base_tbl_t [EXP_STEPS];

    function automatic logic [31:0] isqrt_c(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] one;
        v   = v_in;
        res = 64'd0;
        one = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (one > v) begin
                one = one >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (one != 64'd0) begin
                if (v >= res + one) begin
                    v   = v - (res + one);
                    res = (res >> 1) + one;
                end else begin
                    res = res >> 1;
                end
                one = one >> 2;
            end
        end
        return res[31:0];
    endfunction

    // Factors 2^(-2^-k) in Q.32 for k = 1 .. EXP_STEPS, each the root of the one before.
    function automatic base_tbl_t exp_base_table();
        base_tbl_t   tbl;
        logic [31:0] b;
        b = 32'd3037000500;
        for (int k = 0; k < EXP_STEPS; k++) begin
            tbl[k] = b;
            b = isqrt_c({b, 32'd0});
        end
        return tbl;
    endfunction

endpackage

FILE: hdl/sbct_cell.sv
module sbct_cell (
    input  logic                          aclk,
    input  logic [sbct_pkg::PT_IDX_W-1:0] cell_idx,
    input  sbct_pkg::cell_cmd_t           cmd,
    input  sbct_pkg::point_t              left_pt,
    input  sbct_pkg::point_t              right_pt,
    input  sbct_pkg::point_t              right_tap,
    output sbct_pkg::point_t              pt,
    output sbct_pkg::point_t              tap
);
    import sbct_pkg::*;

    point_t pt_reg;
    point_t pt_next;
    point_t tap_reg;
    point_t tap_next;

    always_comb begin
        pt_next  = pt_reg;
        tap_next = tap_reg;
        case (cmd.op)
            CELL_INSERT: begin
                if (cell_idx > cmd.pos) begin
                    pt_next = left_pt;
                end else if (cell_idx == cmd.pos) begin
                    pt_next = cmd.pt;
                end
            end
            CELL_WRITE: begin
                if (cell_idx == cmd.pos) begin
                    pt_next = cmd.pt;
                end
            end
            CELL_ERASE: begin
                if (cell_idx >= cmd.pos) begin
                    pt_next = right_pt;
                end
            end
            CELL_CURVE: begin
                if (cell_idx == cmd.pos) begin
                    pt_next.curve = cmd.pt.curve;
                end
            end
            CELL_LOAD:  tap_next = pt_reg;
            CELL_SHIFT: tap_next = right_tap;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        pt_reg  <= pt_next;
        tap_reg <= tap_next;
    end

    assign pt  = pt_reg;
    assign tap = tap_reg;

endmodule

FILE: hdl/sbct_div.sv
module sbct_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [sbct_pkg::DIV_W-1:0] dividend,
    input  logic [31:0]                divisor,
    output logic                       done,
    output logic [sbct_pkg::DIV_W-1:0] quot
);
    import sbct_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [32:0]      rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [31:0]      div_reg, div_next;
    logic [32:0]      trial;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        trial     = {rem_reg[31:0], quo_reg[DIV_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = 33'd0;
            quo_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

FILE: hdl/sbct_interp.sv
module sbct_interp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  sbct_pkg::seg_t     seg,
    output logic               done,
    output logic signed [31:0] y_res
);
    import sbct_pkg::*;

    localparam logic [3:0] I_IDLE  = 4'd0;
    localparam logic [3:0] I_DIVT  = 4'd1;
    localparam logic [3:0] I_LOG   = 4'd2;
    localparam logic [3:0] I_MULE  = 4'd3;
    localparam logic [3:0] I_DIVS  = 4'd4;
    localparam logic [3:0] I_DIVE  = 4'd5;
    localparam logic [3:0] I_EXP   = 4'd6;
    localparam logic [3:0] I_ROUND = 4'd7;
    localparam logic [3:0] I_MULY  = 4'd8;
    localparam logic [3:0] I_FIN   = 4'd9;

    localparam base_tbl_t EXP_BASE = exp_base_table();

    logic [3:0]         st_reg, st_next;
    seg_t               seg_reg, seg_next;
    logic [31:0]        m_reg, m_next;
    logic [23:0]        frac_reg, frac_next;
    logic [3:0]         p_reg, p_next;
    logic [4:0]         k_reg, k_next;
    logic [28:0]        l_reg, l_next;
    logic [43:0]        prod_reg, prod_next;
    logic [32:0]        r_reg, r_next;
    logic [23:0]        f_reg, f_next;
    logic [4:0]         ip_reg, ip_next;
    logic [16:0]        s_reg, s_next;
    logic signed [50:0] mul_reg, mul_next;

    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [31:0]        div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;

    logic [16:0]        t_w;
    logic [3:0]         pp;
    logic [47:0]        m_init;
    logic [63:0]        sq;
    logic [33:0]        m2;
    logic [16:0]        num_w;
    logic [16:0]        den_w;
    logic [64:0]        rp;
    logic [33:0]        rnd;
    logic signed [32:0] dy;
    logic signed [50:0] yq;

    sbct_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot)
    );

    always_comb begin
        st_next      = st_reg;
        seg_next     = seg_reg;
        m_next       = m_reg;
        frac_next    = frac_reg;
        p_next       = p_reg;
        k_next       = k_reg;
        l_next       = l_reg;
        prod_next    = prod_reg;
        r_next       = r_reg;
        f_next       = f_reg;
        ip_next      = ip_reg;
        s_next       = s_reg;
        mul_next     = mul_reg;
        div_start    = 1'b0;
        div_dividend = {1'b0, seg.x - seg.xl, 16'd0};
        div_divisor  = {1'b0, seg.xr - seg.xl};
        done         = 1'b0;
        t_w          = div_quot[16:0];
        pp           = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (|(t_w >> i)) begin
                pp = 4'(i);
            end
        end
        m_init = 48'(t_w) << (5'd30 - {1'b0, pp});
        sq     = 64'(m_reg) * 64'(m_reg);
        m2     = sq[63:30];
        num_w  = 17'($signed(seg_reg.cr) + 17'sd16384);
        den_w  = 17'(17'sd16384 - $signed(seg_reg.cr));
        rp     = 65'(r_reg) * 65'(EXP_BASE[k_reg]);
        rnd    = 34'(r_reg >> ip_reg) + 34'd32768;
        dy     = 33'(seg_reg.yr) - 33'(seg_reg.yl);
        yq     = (mul_reg + 51'sd32768) >>> 16;
        y_res  = seg_reg.yl + yq[31:0];
        case (st_reg)
            I_IDLE: begin
                if (start) begin
                    seg_next  = seg;
                    div_start = 1'b1;
                    st_next   = I_DIVT;
                end
            end
            I_DIVT: begin
                if (div_done) begin
                    st_next = I_MULY;
                    if (seg_reg.cr == 16'sd0) begin
                        s_next = t_w;
                    end else if (seg_reg.cr >= 16'sd16384) begin
                        s_next = t_w[16] ? 17'd65536 : 17'd0;
                    end else if (seg_reg.cr <= -16'sd16384) begin
                        s_next = (t_w != 17'd0) ? 17'd65536 : 17'd0;
                    end else if (t_w == 17'd0) begin
                        s_next = 17'd0;
                    end else begin
                        p_next    = pp;
                        m_next    = m_init[31:0];
                        frac_next = 24'd0;
                        k_next    = 5'd0;
                        st_next   = I_LOG;
                    end
                end
            end
            I_LOG: begin
                // One squaring per cycle gives one fraction bit of the logarithm.
                if (|m2[33:31]) begin
                    m_next    = m2[32:1];
                    frac_next = {frac_reg[22:0], 1'b1};
                end else begin
                    m_next    = m2[31:0];
                    frac_next = {frac_reg[22:0], 1'b0};
                end
                k_next = k_reg + 5'd1;
                if (k_reg == 5'(EXP_STEPS - 1)) begin
                    l_next  = {5'd16 - {1'b0, p_reg}, 24'd0} - {5'd0, frac_next};
                    st_next = I_MULE;
                end
            end
            I_MULE: begin
                prod_next = 44'(l_reg) * 44'(num_w[14:0]);
                st_next   = I_DIVS;
            end
            I_DIVS: begin
                div_start    = 1'b1;
                div_dividend = 48'(prod_reg);
                div_divisor  = 32'(den_w[14:0]);
                st_next      = I_DIVE;
            end
            I_DIVE: begin
                if (div_done) begin
                    if (|div_quot[DIV_W-1:29]) begin
                        s_next  = 17'd0;
                        st_next = I_MULY;
                    end else begin
                        ip_next = div_quot[28:24];
                        f_next  = div_quot[23:0];
                        r_next  = 33'h1_0000_0000;
                        k_next  = 5'd0;
                        st_next = I_EXP;
                    end
                end
            end
            I_EXP: begin
                if (f_reg[23]) begin
                    r_next = rp[64:32];
                end
                f_next = {f_reg[22:0], 1'b0};
                k_next = k_reg + 5'd1;
                if (k_reg == 5'(EXP_STEPS - 1)) begin
                    st_next = I_ROUND;
                end
            end
            I_ROUND: begin
                s_next  = rnd[32:16];
                st_next = I_MULY;
            end
            I_MULY: begin
                mul_next = 51'($signed({1'b0, s_reg}) * dy);
                st_next  = I_FIN;
            end
            I_FIN: begin
                done    = 1'b1;
                st_next = I_IDLE;
            end
            default: st_next = I_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= I_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        seg_reg  <= seg_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        p_reg    <= p_next;
        k_reg    <= k_next;
        l_reg    <= l_next;
        prod_reg <= prod_next;
        r_reg    <= r_next;
        f_reg    <= f_next;
        ip_reg   <= ip_next;
        s_reg    <= s_next;
        mul_reg  <= mul_next;
    end

endmodule

FILE: hdl/sorted_breakpoint_curve_table_core.sv
// Sorted breakpoint table with shaped segments. The block holds up to 64
// breakpoints (x, y, curve) in a chain of cells kept sorted by ascending x, and
// handles one item at a time: s_ready is high only while the block is idle. Every
// read goes through the chain's tap registers, which are loaded in parallel and then
// shifted toward cell 0 one point per cycle while a dump or ramp is not waiting on the
// output, so a lookup takes longer the more points it passes. Add and set scan for the
// position, then all cells shift together; erase shifts all cells without a scan. Dump
// and ramp give one result per cycle while the output is taken. A query inside a
// segment adds the shaping unit: a restoring division and, for a curve other than
// 0 or +-1.0, a second one, with 24 squaring steps for the logarithm and 24 multiply
// steps for the power. A finished result waits in an output register and does not
// hold back the next item's work. Configuration is written by the user through
// cfg_wr_en, cfg_index and cfg_wdata while the block is idle; the block does not enforce it.
module sorted_breakpoint_curve_table_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sbct_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sbct_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wdata
);
    import sbct_pkg::*;

    // Controller states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_ERASE = 3'd3;
    localparam logic [2:0] ST_STORE = 3'd4;
    localparam logic [2:0] ST_CURVE = 3'd5;
    localparam logic [2:0] ST_MATH  = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    // What a scan of the chain is looking for.
    localparam logic [1:0] MODE_QUERY = 2'd0;
    localparam logic [1:0] MODE_LB    = 2'd1;
    localparam logic [1:0] MODE_PICK  = 2'd2;
    localparam logic [1:0] MODE_LIST  = 2'd3;

    logic [2:0]          state_reg, state_next;
    logic [1:0]          mode_reg, mode_next;
    logic [3:0]          op_reg, op_next;
    logic [30:0]         x_reg, x_next;
    logic signed [31:0]  y_reg, y_next;
    logic signed [15:0]  c_reg, c_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PT_IDX_W-1:0] p_reg, p_next;
    logic [CNT_W-1:0]    at_reg, at_next;
    logic                eq_reg, eq_next;
    logic [30:0]         prev_x_reg, prev_x_next;
    logic signed [31:0]  prev_y_reg, prev_y_next;
    logic signed [31:0]  res_y_reg, res_y_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg, out_next;
    logic signed [31:0]  bound_a_reg, bound_b_reg;
    logic [CNT_W-1:0]    capacity_reg;

    cell_cmd_t           cell_cmd;
    point_t              cell_pt  [POINT_DEPTH];
    point_t              cell_tap [POINT_DEPTH];
    point_t              head;

    logic                interp_start;
    seg_t                interp_seg;
    logic                interp_done;
    logic signed [31:0]  interp_y;

    logic                out_free;
    logic                out_load;
    out_item_t           out_item;
    logic [CNT_W-1:0]    cap_lim;
    logic [CNT_W-1:0]    cnt_m1;
    logic                at_end;
    logic [30:0]         in_x;
    logic signed [31:0]  in_y;
    logic signed [15:0]  in_c;
    logic signed [31:0]  y_lo, y_hi;
    logic                idx_ok;

    // The chain of cells. Cell i sees its neighbors' points and the tap of cell i+1.
    genvar gi;
    for (gi = 0; gi < POINT_DEPTH; gi++) begin : g_cell
        point_t left_pt;
        point_t right_pt;
        point_t right_tap;
        if (gi == 0) begin : g_first
            assign left_pt = '0;
        end else begin : g_left
            assign left_pt = cell_pt[gi-1];
        end
        if (gi == POINT_DEPTH - 1) begin : g_last
            assign right_pt  = '0;
            assign right_tap = '0;
        end else begin : g_right
            assign right_pt  = cell_pt[gi+1];
            assign right_tap = cell_tap[gi+1];
        end
        sbct_cell u_cell (
            .aclk      (aclk),
            .cell_idx  (PT_IDX_W'(gi)),
            .cmd       (cell_cmd),
            .left_pt   (left_pt),
            .right_pt  (right_pt),
            .right_tap (right_tap),
            .pt        (cell_pt[gi]),
            .tap       (cell_tap[gi])
        );
    end

    assign head = cell_tap[0];

    sbct_interp u_interp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (interp_start),
        .seg     (interp_seg),
        .done    (interp_done),
        .y_res   (interp_y)
    );

    // The segment runs from the last point passed to the point now at the head.
    assign interp_seg = '{x: x_reg, xl: prev_x_reg, yl: prev_y_reg,
                          xr: head.x, yr: head.y, cr: head.curve};

    always_comb begin
        if (capacity_reg < CNT_W'(2)) begin
            cap_lim = CNT_W'(2);
        end else if (capacity_reg > CNT_W'(POINT_DEPTH)) begin
            cap_lim = CNT_W'(POINT_DEPTH);
        end else begin
            cap_lim = capacity_reg;
        end
    end

    // Input folding: negative x to zero, y into the ordered bounds, curve to +-1.0.
    always_comb begin
        in_x = s_data.x_in[31] ? 31'd0 : s_data.x_in[30:0];
        y_lo = (bound_a_reg < bound_b_reg) ? bound_a_reg : bound_b_reg;
        y_hi = (bound_a_reg < bound_b_reg) ? bound_b_reg : bound_a_reg;
        if (s_data.y_in < y_lo) begin
            in_y = y_lo;
        end else if (s_data.y_in > y_hi) begin
            in_y = y_hi;
        end else begin
            in_y = s_data.y_in;
        end
        if (s_data.curve_in > 16'sd16384) begin
            in_c = 16'sd16384;
        end else if (s_data.curve_in < -16'sd16384) begin
            in_c = -16'sd16384;
        end else begin
            in_c = s_data.curve_in;
        end
    end

    assign idx_ok   = s_data.index_in < IDX_W'(cnt_reg);
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign at_end   = CNT_W'(p_reg) == cnt_m1;
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        op_next      = op_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        c_next       = c_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        p_next       = p_reg;
        at_next      = at_reg;
        eq_next      = eq_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        res_y_next   = res_y_reg;
        interp_start = 1'b0;
        out_load     = 1'b0;
        out_item     = '0;
        cell_cmd.op  = CELL_NOP;
        cell_cmd.pos = idx_reg[PT_IDX_W-1:0];
        cell_cmd.pt  = '{x: x_reg, y: y_reg, curve: c_reg};

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next  = s_data.operation;
                    x_next   = in_x;
                    y_next   = in_y;
                    c_next   = in_c;
                    idx_next = s_data.index_in;
                    case (s_data.operation)
                        OP_QUERY: begin
                            mode_next = MODE_QUERY;
                            if (cnt_reg != '0) begin
                                state_next = ST_LOAD;
                            end
                        end
                        OP_ADD: begin
                            c_next = 16'sd0;
                            if (cnt_reg == '0) begin
                                at_next    = '0;
                                eq_next    = 1'b0;
                                state_next = ST_STORE;
                            end else begin
                                mode_next  = MODE_LB;
                                state_next = ST_LOAD;
                            end
                        end
                        OP_SET_C: begin
                            if (idx_ok) begin
                                state_next = ST_ERASE;
                            end
                        end
                        OP_SET_K, OP_NTH: begin
                            mode_next = MODE_PICK;
                            if (idx_ok) begin
                                state_next = ST_LOAD;
                            end
                        end
                        OP_CURVE: begin
                            if (idx_ok) begin
                                state_next = ST_CURVE;
                            end
                        end
                        OP_CLEAR: cnt_next = '0;
                        OP_ERASE: begin
                            if (idx_ok) begin
                                state_next = ST_ERASE;
                            end
                        end
                        OP_DUMP, OP_RAMP: begin
                            mode_next = MODE_LIST;
                            if (cnt_reg != '0) begin
                                state_next = ST_LOAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_LOAD: begin
                // Copy every point into its tap register; the scan then shifts them out.
                cell_cmd.op = CELL_LOAD;
                p_next      = '0;
                state_next  = ST_SCAN;
            end

            ST_SCAN: begin
                case (mode_reg)
                    MODE_LB: begin
                        if (head.x >= x_reg) begin
                            at_next    = CNT_W'(p_reg);
                            eq_next    = (head.x == x_reg);
                            state_next = ST_STORE;
                        end else if (at_end) begin
                            at_next    = cnt_reg;
                            eq_next    = 1'b0;
                            state_next = ST_STORE;
                        end else begin
                            cell_cmd.op = CELL_SHIFT;
                            p_next      = p_reg + PT_IDX_W'(1);
                        end
                    end
                    MODE_QUERY: begin
                        if (head.x >= x_reg) begin
                            if (p_reg == '0) begin
                                // At or before the first point: its y.
                                res_y_next = head.y;
                                state_next = ST_EMIT;
                            end else begin
                                interp_start = 1'b1;
                                state_next   = ST_MATH;
                            end
                        end else if (at_end) begin
                            // Past the last point: its y.
                            res_y_next = head.y;
                            state_next = ST_EMIT;
                        end else begin
                            prev_x_next = head.x;
                            prev_y_next = head.y;
                            cell_cmd.op = CELL_SHIFT;
                            p_next      = p_reg + PT_IDX_W'(1);
                        end
                    end
                    MODE_PICK: begin
                        if (IDX_W'(p_reg) == idx_reg) begin
                            if (op_reg == OP_NTH) begin
                                res_y_next = head.y;
                                state_next = ST_EMIT;
                            end else begin
                                // Set that keeps the old curve of the point.
                                c_next     = head.curve;
                                state_next = ST_ERASE;
                            end
                        end else begin
                            cell_cmd.op = CELL_SHIFT;
                            p_next      = p_reg + PT_IDX_W'(1);
                        end
                    end
                    default: begin
                        // Dump and ramp: one result per point, as fast as the output drains.
                        if (out_free) begin
                            out_load      = 1'b1;
                            out_item.y_out = head.y;
                            out_item.last = at_end;
                            if (op_reg == OP_DUMP) begin
                                out_item.kind      = KIND_DUMP;
                                out_item.index_out = IDX_W'(p_reg);
                                out_item.x_out     = head.x;
                                out_item.curve_out = head.curve;
                            end else begin
                                out_item.kind     = KIND_RAMP;
                                out_item.time_out = (p_reg == '0) ? 31'd0 : head.x - prev_x_reg;
                            end
                            prev_x_next = head.x;
                            if (at_end) begin
                                state_next = ST_IDLE;
                            end else begin
                                cell_cmd.op = CELL_SHIFT;
                                p_next      = p_reg + PT_IDX_W'(1);
                            end
                        end
                    end
                endcase
            end

            ST_ERASE: begin
                cell_cmd.op = CELL_ERASE;
                cnt_next    = cnt_m1;
                if (op_reg == OP_ERASE) begin
                    state_next = ST_IDLE;
                end else if (cnt_m1 == '0) begin
                    at_next    = '0;
                    eq_next    = 1'b0;
                    state_next = ST_STORE;
                end else begin
                    mode_next  = MODE_LB;
                    state_next = ST_LOAD;
                end
            end

            ST_STORE: begin
                cell_cmd.pos = at_reg[PT_IDX_W-1:0];
                if (eq_reg) begin
                    // Same x: the whole point is replaced in place.
                    cell_cmd.op = CELL_WRITE;
                end else if (cnt_reg < cap_lim) begin
                    cell_cmd.op = CELL_INSERT;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                state_next = ST_IDLE;
            end

            ST_CURVE: begin
                cell_cmd.op = CELL_CURVE;
                state_next  = ST_IDLE;
            end

            ST_MATH: begin
                if (interp_done) begin
                    res_y_next = interp_y;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_item.kind  = KIND_Y;
                    out_item.y_out = res_y_reg;
                    out_item.last  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_next       = out_item;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            bound_a_reg   <= 32'sd0;
            bound_b_reg   <= 32'sd65536;
            capacity_reg  <= CNT_W'(POINT_DEPTH);
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_Y_BOUND_A: bound_a_reg  <= cfg_wdata;
                    REG_Y_BOUND_B: bound_b_reg  <= cfg_wdata;
                    REG_CAPACITY:  capacity_reg <= cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        op_reg     <= op_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        c_reg      <= c_next;
        idx_reg    <= idx_next;
        p_reg      <= p_next;
        at_reg     <= at_next;
        eq_reg     <= eq_next;
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
        res_y_reg  <= res_y_next;
        out_reg    <= out_next;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready || $past(s_data.operation) == OP_CLEAR
            || $past(s_data.operation) == OP_QUERY || $past(s_data.operation) > OP_RAMP
            || $past(cnt_reg) == '0 || !$past(idx_ok)))
        else $error("item accepted without starting work");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (cnt_reg == $past(cnt_reg) || cnt_reg == $past(cnt_reg) + CNT_W'(1)
            || cnt_reg == $past(cnt_reg) - CNT_W'(1) || cnt_reg == '0))
        else $error("point count jumped");

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_cmd.op == CELL_INSERT) |-> (cnt_reg < cap_lim))
        else $error("insert into a full table");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg != '0 && CNT_W'(p_reg) < cnt_reg))
        else $error("scan past the stored points");
`endif

endmodule
